/* design/sliding_window_peak_to_peak_assert.svh */
// Assertion macros for the sliding window peak-to-peak block
`ifndef SLIDING_WINDOW_PEAK_TO_PEAK_ASSERT_SVH
`define SLIDING_WINDOW_PEAK_TO_PEAK_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define SWPP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication
`define SWPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define SWPP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SWPP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/swpp_pkg.sv */
`timescale 1ns / 1ps
package swpp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int P2P_W    = 16;
  localparam int WL_W     = 9;

  localparam logic [WL_W-1:0]     WL_RESET = 9'd64;
  localparam logic [SAMPLE_W-1:0] HI_INIT  = 16'h0000;
  localparam logic [SAMPLE_W-1:0] LO_INIT  = 16'hFFFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming sample
    logic store;    // write the ring, advance the index, start the walk
    logic step;     // issue one ring read and move back one entry
    logic emit;     // load the result register
  } swpp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic span_zero;  // window is empty
    logic last;       // the read being issued is the oldest in the window
    logic out_free;   // result register can take a new value
  } swpp_sts_t;

endpackage

/* design/swpp_in_if.sv */
`timescale 1ns / 1ps
interface swpp_in_if import swpp_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* design/swpp_out_if.sv */
`timescale 1ns / 1ps
interface swpp_out_if import swpp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [P2P_W-1:0] peak_to_peak;

  modport source (output valid, output peak_to_peak, input ready);
  modport sink   (input valid, input peak_to_peak, output ready);
endinterface

/* design/sliding_window_peak_to_peak.sv */
// The result is shown after a walk that reads the window of length W (clamped to
// RING_DEPTH) with one ring read per window entry; an empty window skips the walk.
// A new sample is not taken until the walk for the last one is through and its
// result is loaded. The result register lets the next sample in while a result waits.
// Reset (rst_n, synchronous, active low) zeroes the ring index and sets the window
// length to 64; unwritten ring entries read as zero without a clearing pass.
`timescale 1ns / 1ps
`include "sliding_window_peak_to_peak_assert.svh"
module sliding_window_peak_to_peak import swpp_pkg::*; #(
  parameter int RING_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  swpp_in_if.sink         in_if,
  swpp_out_if.source      out_if,
  input  logic            cfg_we,
  input  logic [WL_W-1:0] cfg_wdata
);

  swpp_cmd_t cmd;
  swpp_sts_t sts;

  swpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swpp_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_sample        (in_if.sample),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_peak_to_peak (out_if.peak_to_peak),
    .cmd              (cmd),
    .sts              (sts)
  );

  // A result is loaded only when the result register can take it
  `SWPP_ASSERT_IMPLY(a_emit_free, clk, rst_n, cmd.emit, sts.out_free)
  // An accepted sample closes the input until its range is out
  `SWPP_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready)
  // Loading a result always shows it on the next cycle
  `SWPP_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit, out_if.valid)

endmodule

/* design/swpp_ram.sv */
`timescale 1ns / 1ps
module swpp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/swpp_ctrl.sv */
`timescale 1ns / 1ps
module swpp_ctrl import swpp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  swpp_sts_t sts,
  output swpp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_STORE = 5'b00010,
    S_WALK  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Sequence one sample: take it, store it, walk the window, hand over the range
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = sts.span_zero ? S_EMIT : S_WALK;
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/swpp_dp.sv */
`timescale 1ns / 1ps
module swpp_dp import swpp_pkg::*; #(
  parameter int RING_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [WL_W-1:0]     cfg_wdata,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [P2P_W-1:0]    out_peak_to_peak,
  input  swpp_cmd_t           cmd,
  output swpp_sts_t           sts
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int SW = (RING_DEPTH >= 511) ? WL_W : $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  logic [WL_W-1:0]     wl_r;
  logic [SAMPLE_W-1:0] smp_r;
  logic [AW-1:0]       wr_idx_r, wr_idx_nxt;
  logic                full_r;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [SW-1:0]       cnt_r;
  logic [SW-1:0]       span;
  logic                rd_vld_r;
  logic                rd_ok_r;
  logic [SAMPLE_W-1:0] hi_r, lo_r;
  logic                out_vld_r;
  logic [P2P_W-1:0]    out_p2p_r;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] rd_val;

  // Clamp the window to the ring
  always_comb begin
    if (32'(wl_r) > RING_DEPTH) begin
      span = SW'(RING_DEPTH);
    end else begin
      span = SW'(wl_r);
    end
  end

  assign wr_idx_nxt = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + AW'(1);
  assign pos_nxt    = (pos_r == '0) ? LAST_IDX : pos_r - AW'(1);

  assign sts.span_zero = (span == '0);
  assign sts.last      = (cnt_r == SW'(1));
  assign sts.out_free  = !out_vld_r || out_ready;

  swpp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (wr_idx_r),
    .wdata (smp_r),
    .re    (cmd.step),
    .raddr (pos_r),
    .rdata (rd_data)
  );

  // Entries not yet written since reset read as zero
  assign rd_val = rd_ok_r ? rd_data : '0;

  // Control state: register, ring index, walk counter, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r      <= WL_RESET;
      wr_idx_r  <= '0;
      full_r    <= 1'b0;
      cnt_r     <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        wl_r <= cfg_wdata;
      end
      if (cmd.store) begin
        wr_idx_r <= wr_idx_nxt;
        if (wr_idx_r == LAST_IDX) begin
          full_r <= 1'b1;
        end
        cnt_r <= span;
      end else if (cmd.step) begin
        cnt_r <= cnt_r - SW'(1);
      end
      rd_vld_r <= cmd.step;
      if (cmd.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload: sample, walk position, running extremes, result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_r <= in_sample;
    end
    if (cmd.store) begin
      pos_r <= wr_idx_r;
      hi_r  <= HI_INIT;
      lo_r  <= (span == '0) ? HI_INIT : LO_INIT;
    end else begin
      if (cmd.step) begin
        pos_r   <= pos_nxt;
        rd_ok_r <= full_r || (pos_r < wr_idx_r);
      end
      if (rd_vld_r) begin
        if (rd_val > hi_r) begin
          hi_r <= rd_val;
        end
        if (rd_val < lo_r) begin
          lo_r <= rd_val;
        end
      end
    end
    if (cmd.emit) begin
      out_p2p_r <= hi_r - lo_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_peak_to_peak = out_p2p_r;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import swpp_pkg::*;

  localparam int RING_DEPTH = 256;
  localparam int DIRECTED_ROWS = 16;
  localparam int RANDOM_ITEMS = 950;
  localparam int DRAIN_CYCLES = RING_DEPTH + 40;

  typedef struct packed {
    logic                set_window;
    logic [WL_W-1:0]     window;
    logic [SAMPLE_W-1:0] sample;
    logic                known;
    logic [P2P_W-1:0]    p2p;
  } directed_row_t;

  // Directed walk: reset window first, then single entry, two entry, empty, whole ring
  // and saturated windows, then windows of 3, 255 and 128. Typed results only where the window content is obvious.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, 9'd0,   16'hFFFF, 1'b1, 16'hFFFF},
    '{1'b0, 9'd0,   16'h0000, 1'b1, 16'hFFFF},
    '{1'b1, 9'd1,   16'h1234, 1'b1, 16'h0000},
    '{1'b0, 9'd0,   16'hFFFF, 1'b1, 16'h0000},
    '{1'b1, 9'd2,   16'h0000, 1'b1, 16'hFFFF},
    '{1'b0, 9'd0,   16'h0001, 1'b1, 16'h0001},
    '{1'b1, 9'd0,   16'hABCD, 1'b1, 16'h0000},
    '{1'b1, 9'd256, 16'h8000, 1'b1, 16'hFFFF},
    '{1'b1, 9'd511, 16'h5555, 1'b1, 16'hFFFF},
    '{1'b1, 9'd257, 16'h0000, 1'b1, 16'hFFFF},
    '{1'b1, 9'd3,   16'h7FFF, 1'b0, 16'h0000},
    '{1'b0, 9'd0,   16'h8000, 1'b0, 16'h0000},
    '{1'b0, 9'd0,   16'hAAAA, 1'b0, 16'h0000},
    '{1'b1, 9'd255, 16'h5555, 1'b0, 16'h0000},
    '{1'b1, 9'd128, 16'h0F0F, 1'b0, 16'h0000},
    '{1'b0, 9'd0,   16'hF0F0, 1'b0, 16'h0000}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [WL_W-1:0] cfg_wdata;

  swpp_in_if  in_ch ();
  swpp_out_if out_ch ();

  sliding_window_peak_to_peak #(
    .RING_DEPTH (RING_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the ring, its write pointer and the window register
  logic [SAMPLE_W-1:0] ring_model [RING_DEPTH];
  logic [7:0]          ring_wr_ptr;
  logic [WL_W-1:0]     window_model;

  logic [P2P_W-1:0] p2p_expected [$];
  int mismatch_count = 0;
  int burst_left;
  int quiet_left = 0;
  int stall_left = 0;

  // Store the sample, then scan back over the window for max and min
  function automatic logic [P2P_W-1:0] predict_peak_to_peak(input logic [SAMPLE_W-1:0] s);
    int span;
    logic [7:0] pos;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;
    ring_model[ring_wr_ptr] = s;
    ring_wr_ptr = ring_wr_ptr + 8'd1;
    span = (window_model > RING_DEPTH) ? RING_DEPTH : int'(window_model);
    if (span == 0) return '0;
    hi = HI_INIT;
    lo = LO_INIT;
    pos = ring_wr_ptr;
    for (int k = 0; k < span; k++) begin
      pos = pos - 8'd1;
      if (ring_model[pos] > hi) hi = ring_model[pos];
      if (ring_model[pos] < lo) lo = ring_model[pos];
    end
    return hi - lo;
  endfunction

  // Offer one sample, with a random gap at the start of each burst; called and
  // returning at a falling edge
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic known,
                             input logic [P2P_W-1:0] typed);
    int gap;
    logic [P2P_W-1:0] predicted;
    if (burst_left == 0) begin
      case ($urandom_range(0, 5))
        0, 1: gap = 0;
        2, 3: gap = $urandom_range(1, 8);
        4: gap = $urandom_range(9, 60);
        default: gap = $urandom_range(61, 280);
      endcase
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid = 1'b1;
    in_ch.sample = s;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_peak_to_peak(s);
    p2p_expected.push_back(known ? typed : predicted);
    burst_left--;
    @(negedge clk);
  endtask

  // Write the window register once every pending result has been taken
  task automatic set_window(input logic [WL_W-1:0] w);
    in_ch.valid = 1'b0;
    while (p2p_expected.size() != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = w;
    @(negedge clk);
    cfg_we = 1'b0;
    window_model = w;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: quiet stretches, short stalls and the odd long one
  always @(negedge clk) begin
    if (quiet_left > 0) begin
      quiet_left--;
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
      case ($urandom_range(0, 15))
        0: quiet_left = $urandom_range(100, 600);
        1, 2, 3: stall_left = $urandom_range(1, 20);
        4: stall_left = $urandom_range(50, 300);
        default: ;
      endcase
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (p2p_expected.size() == 0) begin
        $error("unexpected result: peak_to_peak actual %0h", out_ch.peak_to_peak);
        mismatch_count++;
      end else begin
        logic [P2P_W-1:0] want;
        want = p2p_expected.pop_front();
        if (out_ch.peak_to_peak !== want) begin
          $error("peak_to_peak mismatch: expected %0h actual %0h", want,
                 out_ch.peak_to_peak);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int sent;
    int phase_items;
    int phase;
    logic [WL_W-1:0] w;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] s;
    logic [WL_W-1:0] extreme_windows [7];

    extreme_windows = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd2, 9'd257, 9'd255};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    burst_left = 0;
    for (int i = 0; i < RING_DEPTH; i++) ring_model[i] = '0;
    ring_wr_ptr = '0;
    window_model = WL_RESET;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].set_window) set_window(DIRECTED[r].window);
      send_sample(DIRECTED[r].sample, DIRECTED[r].known, DIRECTED[r].p2p);
    end

    // Random phases: extremes of the window first, then mostly short windows
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase < 7) w = extreme_windows[phase];
      else if ($urandom_range(0, 3) != 0) w = WL_W'($urandom_range(1, 32));
      else w = WL_W'($urandom_range(0, 511));
      set_window(w);
      base = SAMPLE_W'($urandom);
      phase_items = $urandom_range(30, 60);
      for (int n = 0; n < phase_items && sent < RANDOM_ITEMS; n++) begin
        case ($urandom_range(0, 7))
          0: s = 16'h0000;
          1: s = 16'hFFFF;
          2, 3, 4: s = base + SAMPLE_W'($urandom_range(0, 255));
          default: s = SAMPLE_W'($urandom);
        endcase
        send_sample(s, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    // Drain, then allow late strays to show up
    in_ch.valid = 1'b0;
    while (p2p_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/swpp_pkg.sv
design/swpp_in_if.sv
design/swpp_out_if.sv
design/swpp_ram.sv
design/swpp_ctrl.sv
design/swpp_dp.sv
design/sliding_window_peak_to_peak.sv
tb/sv/tb.sv
